@@ hdl/assert_macros.svh @@
// Assertion macros shared by the hasher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SBSH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SBSH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBSH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SBSH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/sbsh_pkg.sv @@
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; used by sbsh_round and the top level.
package sbsh_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Working variables of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428A2F98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;
      6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;
      6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;
      6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;
      6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;
      6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;
      6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;
      6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;
      6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;
      6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;
      6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;
      6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;
      6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;
      6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;
      6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;
      6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;
      6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;
      6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;
      6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;
      6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;
      6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;
      6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/sbsh_round.sv @@
// One SHA-256 round plus one message schedule step, purely combinational.
// Depends on sbsh_pkg (work_t).
module sbsh_round (
  input  sbsh_pkg::work_t work_i,
  input  logic [31:0]     k_i,
  input  logic [31:0]     w0_i,   // w[t]
  input  logic [31:0]     w1_i,   // w[t+1]
  input  logic [31:0]     w9_i,   // w[t+9]
  input  logic [31:0]     w14_i,  // w[t+14]
  output sbsh_pkg::work_t work_o,
  output logic [31:0]     w16_o   // w[t+16]
);

  logic [31:0] big1;
  logic [31:0] big0;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sig0;
  logic [31:0] sig1;

  always_comb begin
    big1 = {work_i.e[5:0], work_i.e[31:6]} ^ {work_i.e[10:0], work_i.e[31:11]} ^
           {work_i.e[24:0], work_i.e[31:25]};
    big0 = {work_i.a[1:0], work_i.a[31:2]} ^ {work_i.a[12:0], work_i.a[31:13]} ^
           {work_i.a[21:0], work_i.a[31:22]};
    ch   = (work_i.e & work_i.f) ^ (~work_i.e & work_i.g);
    maj  = (work_i.a & work_i.b) ^ (work_i.a & work_i.c) ^ (work_i.b & work_i.c);
    t1   = work_i.h + big1 + ch + k_i + w0_i;
    t2   = big0 + maj;

    work_o.h = work_i.g;
    work_o.g = work_i.f;
    work_o.f = work_i.e;
    work_o.e = work_i.d + t1;
    work_o.d = work_i.c;
    work_o.c = work_i.b;
    work_o.b = work_i.a;
    work_o.a = t1 + t2;

    sig0  = {w1_i[6:0], w1_i[31:7]} ^ {w1_i[17:0], w1_i[31:18]} ^ {3'b000, w1_i[31:3]};
    sig1  = {w14_i[16:0], w14_i[31:17]} ^ {w14_i[18:0], w14_i[31:19]} ^
            {10'b0, w14_i[31:10]};
    w16_o = w0_i + sig0 + w9_i + sig1;
  end

endmodule

@@ hdl/sha256_byte_stream_hasher_top.sv @@
// SHA-256 byte stream hasher, top level.
// Depends on sbsh_pkg, sbsh_round and assert_macros.svh.
`include "assert_macros.svh"

// Feed a message one byte per input beat with in_tuser[0] low; end it with one
// beat with in_tuser[0] high (in_tdata ignored). The block then returns the
// SHA-256 digest as eight output beats, word 0 (most significant) first, with
// out_tlast on the eighth, and is ready for the next message. A data byte is
// taken while idle; the 64th byte of a block loads the working variables and
// starts the compression on a single shared round unit, after which the
// working variables are added back into the hash. A finish beat is accepted,
// then the padding is shifted in, one byte per cycle, then the block is
// compressed; when the fill is 56 or more the padding spans a second block,
// and a second padding pass and compression follow. in_tready is low from
// the finish beat until the last digest beat is taken.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic [0:0]  in_tuser,    // [0] op: 0 absorb, 1 finish
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] digest_word, [34:32] word_index, zeros above
  output logic        out_tlast    // last_word
);

  sbsh_pkg::state_t state_r, state_nxt;
  logic [5:0]       fill_r, fill_nxt;       // bytes held in the block shift line
  logic [63:0]      msg_bits_r, msg_bits_nxt;
  logic [511:0]     blk_r, blk_nxt;         // block bytes, then the schedule window
  sbsh_pkg::work_t  work_r, work_nxt;
  logic [31:0]      hash_r [8];
  logic [31:0]      hash_nxt [8];
  logic [5:0]       rnd_r, rnd_nxt;
  logic [2:0]       emit_r, emit_nxt;
  logic             fin_r, fin_nxt;         // finishing a message
  logic             mark_r, mark_nxt;       // 0x80 marker still to go in
  logic             len_ok_r, len_ok_nxt;   // current block carries the length

  logic             in_acc;
  logic             out_acc;
  logic [7:0]       pad_byte;
  sbsh_pkg::work_t  rnd_work;
  logic [31:0]      rnd_w16;
  sbsh_pkg::work_t  load_work;

  // Shared round unit: one round per cycle over the schedule window.
  sbsh_round u_round (
    .work_i (work_r),
    .k_i    (sbsh_pkg::round_k(rnd_r)),
    .w0_i   (blk_r[511:480]),
    .w1_i   (blk_r[479:448]),
    .w9_i   (blk_r[223:192]),
    .w14_i  (blk_r[63:32]),
    .work_o (rnd_work),
    .w16_o  (rnd_w16)
  );

  assign in_tready  = (state_r == sbsh_pkg::ST_IDLE);
  assign out_tvalid = (state_r == sbsh_pkg::ST_EMIT);
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = {5'b0, emit_r, hash_r[0]};
  assign out_tlast  = (emit_r == 3'd7);

  // Padding byte: marker first, then zeros, then the length from its top byte.
  always_comb begin
    if (mark_r) begin
      pad_byte = sbsh_pkg::PAD_MARK;
    end else if (len_ok_r && (fill_r >= sbsh_pkg::LEN_POS)) begin
      pad_byte = msg_bits_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    load_work.a = hash_r[0];
    load_work.b = hash_r[1];
    load_work.c = hash_r[2];
    load_work.d = hash_r[3];
    load_work.e = hash_r[4];
    load_work.f = hash_r[5];
    load_work.g = hash_r[6];
    load_work.h = hash_r[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbsh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    msg_bits_nxt = msg_bits_r;
    blk_nxt      = blk_r;
    work_nxt     = work_r;
    hash_nxt     = hash_r;
    rnd_nxt      = rnd_r;
    emit_nxt     = emit_r;
    fin_nxt      = fin_r;
    mark_nxt     = mark_r;
    len_ok_nxt   = len_ok_r;

    unique case (state_r)
      sbsh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == sbsh_pkg::OP_FINISH) begin
            fin_nxt   = 1'b1;
            mark_nxt  = 1'b1;
            state_nxt = sbsh_pkg::ST_PAD;
          end else begin
            blk_nxt      = {blk_r[503:0], in_tdata};
            msg_bits_nxt = msg_bits_r + 64'd8;
            fill_nxt     = fill_r + 6'd1;
            if (fill_r == sbsh_pkg::LAST_POS) begin
              work_nxt  = load_work;
              rnd_nxt   = 6'd0;
              state_nxt = sbsh_pkg::ST_ROUND;
            end
          end
        end
      end

      sbsh_pkg::ST_PAD: begin
        blk_nxt  = {blk_r[503:0], pad_byte};
        fill_nxt = fill_r + 6'd1;
        if (mark_r) begin
          mark_nxt   = 1'b0;
          // Length fits behind the marker only if the marker lands below byte 56.
          len_ok_nxt = (fill_r < sbsh_pkg::LEN_POS);
        end else if (len_ok_r && (fill_r >= sbsh_pkg::LEN_POS)) begin
          msg_bits_nxt = {msg_bits_r[55:0], 8'h00};
        end
        if (fill_r == sbsh_pkg::LAST_POS) begin
          work_nxt  = load_work;
          rnd_nxt   = 6'd0;
          state_nxt = sbsh_pkg::ST_ROUND;
        end
      end

      sbsh_pkg::ST_ROUND: begin
        work_nxt = rnd_work;
        blk_nxt  = {blk_r[479:0], rnd_w16};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == sbsh_pkg::LAST_POS) begin
          state_nxt = sbsh_pkg::ST_ADD;
        end
      end

      sbsh_pkg::ST_ADD: begin
        hash_nxt[0] = hash_r[0] + work_r.a;
        hash_nxt[1] = hash_r[1] + work_r.b;
        hash_nxt[2] = hash_r[2] + work_r.c;
        hash_nxt[3] = hash_r[3] + work_r.d;
        hash_nxt[4] = hash_r[4] + work_r.e;
        hash_nxt[5] = hash_r[5] + work_r.f;
        hash_nxt[6] = hash_r[6] + work_r.g;
        hash_nxt[7] = hash_r[7] + work_r.h;
        if (!fin_r) begin
          state_nxt = sbsh_pkg::ST_IDLE;
        end else if (len_ok_r) begin
          emit_nxt  = 3'd0;
          state_nxt = sbsh_pkg::ST_EMIT;
        end else begin
          // Marker filled the block; a second block of zeros carries the length.
          len_ok_nxt = 1'b1;
          state_nxt  = sbsh_pkg::ST_PAD;
        end
      end

      sbsh_pkg::ST_EMIT: begin
        if (out_acc) begin
          emit_nxt = emit_r + 3'd1;
          for (int i = 0; i < 7; i++) begin
            hash_nxt[i] = hash_r[i+1];
          end
          hash_nxt[7] = hash_r[7];
          if (emit_r == 3'd7) begin
            hash_nxt     = sbsh_pkg::HASH_IV;
            msg_bits_nxt = 64'd0;
            fill_nxt     = 6'd0;
            fin_nxt      = 1'b0;
            len_ok_nxt   = 1'b0;
            state_nxt    = sbsh_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sbsh_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and hash state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 6'd0;
      msg_bits_r <= 64'd0;
      hash_r     <= sbsh_pkg::HASH_IV;
      fin_r      <= 1'b0;
      mark_r     <= 1'b0;
      len_ok_r   <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      msg_bits_r <= msg_bits_nxt;
      hash_r     <= hash_nxt;
      fin_r      <= fin_nxt;
      mark_r     <= mark_nxt;
      len_ok_r   <= len_ok_nxt;
    end
  end

  // Datapath payload; loaded before use.
  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    work_r <= work_nxt;
    rnd_r  <= rnd_nxt;
    emit_r <= emit_nxt;
  end

  `SBSH_ASSERT_IMP(a_no_in_during_emit, clk, rst_n, in_tready, !out_tvalid, "input open while digest pending")
  `SBSH_ASSERT_IMP(a_round_block_aligned, clk, rst_n, state_r == sbsh_pkg::ST_ROUND, fill_r == 6'd0, "compression with partial block")
  `SBSH_ASSERT_NXT(a_ready_after_digest, clk, rst_n, out_acc && out_tlast, in_tready && (fill_r == 6'd0) && (msg_bits_r == 64'd0), "not reinitialized after digest")

endmodule
